// ===== rtl/bracket_balance_checker_top_assert.svh =====
// ------------------------------------------------------------------------
// bracket balance checker assertion macros
// concurrent checks that compile away for synthesis
// ------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define BBC_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("bbc assertion failed");

`define BBC_ASSERT_NEXT(name, clk, rstn, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("bbc assertion failed");

`else

`define BBC_ASSERT(name, clk, rstn, prop)

`define BBC_ASSERT_NEXT(name, clk, rstn, cond, prop)

`endif

`endif

// ===== rtl/bbc_pkg.sv =====
// ------------------------------------------------------------------------
// bbc_pkg
// types and constants shared by the bracket balance checker
// ------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PAREN   = 2'd0;
    localparam kind_t KIND_SQUARE  = 2'd1;
    localparam kind_t KIND_CURLY   = 2'd2;
    localparam kind_t KIND_NONE    = 2'd3;

    localparam logic [7:0] CHAR_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CHAR_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;

    typedef enum logic [2:0] {
        CAUSE_OK       = 3'd0,
        CAUSE_MISMATCH = 3'd1,
        CAUSE_EMPTY    = 3'd2,
        CAUSE_OPEN     = 3'd3,
        CAUSE_ODD      = 3'd4,
        CAUSE_OVERFLOW = 3'd5
    } cause_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic       balanced;
        logic [2:0] cause;
    } out_item_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        kind_t push_kind;
    } stack_op_t;

endpackage

`default_nettype wire

// ===== rtl/bbc_stack.sv =====
// ------------------------------------------------------------------------
// bbc_stack
// bracket kind stack: top entry in a register, the rest in a memory
// ------------------------------------------------------------------------
`default_nettype none

module bbc_stack #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  bbc_pkg::stack_op_t                   op,
    output logic [$clog2(STACK_DEPTH+1)-1:0]     count,
    output bbc_pkg::kind_t                       top_kind
);
    import bbc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    kind_t          mem [STACK_DEPTH];

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    kind_t          top_reg;
    kind_t          top_next;
    kind_t          rdata_reg;
    logic           fwd_reg;
    kind_t          fwd_val_reg;
    kind_t          second;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;

    // entry just below the top, forwarded when it was written last cycle
    assign second  = fwd_reg ? fwd_val_reg : rdata_reg;
    assign wr_addr = AW'(count_reg - CW'(1));
    assign rd_addr = AW'(count_next - CW'(2));

    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        if (op.push) begin
            count_next = count_reg + CW'(1);
            top_next   = op.push_kind;
        end else if (op.pop) begin
            count_next = count_reg - CW'(1);
            top_next   = second;
        end
        if (op.clear) begin
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (op.push && (count_reg != '0)) begin
            mem[wr_addr] <= top_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            fwd_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            fwd_reg   <= op.push;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg     <= top_next;
        fwd_val_reg <= top_reg;
    end

    assign count    = count_reg;
    assign top_kind = top_reg;

endmodule

`default_nettype wire

// ===== rtl/bracket_balance_checker_top.sv =====
// ------------------------------------------------------------------------
// bracket_balance_checker_top
// checks that the brackets of a byte string are balanced and well nested
// ------------------------------------------------------------------------
// usage
//   s_ channel: one character per item, s_data.last marks the final one
//   m_ channel: one verdict item per string, balanced flag and cause code
//   each character is processed in the cycle it is accepted; the verdict
//   of an item with last set goes to m_ through the output register
//   throughput is one character per cycle while s_ready is high; top of
//   stack in a register, next entry prefetched from the stack memory,
//   with a forward path when it was written in the previous cycle
//   the verdict goes into a two-entry output register, so characters keep
//   flowing while a verdict waits; s_ready is low while the second entry
//   holds a verdict, which happens only after m_ready was low
//   reset empties the stack, clears the latched failure and the length
//   parity, and empties the output register; no clearing pass is needed
//   after the final character the per-string state returns to reset
// ------------------------------------------------------------------------
`default_nettype none

`include "bracket_balance_checker_top_assert.svh"

module bracket_balance_checker_top #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  bbc_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output bbc_pkg::out_item_t  m_data
);
    import bbc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic           accept;
    logic           is_open;
    logic           is_close;
    kind_t          open_kind;
    kind_t          close_kind;
    logic [CW-1:0]  count;
    logic [CW-1:0]  count_after;
    kind_t          top_kind;
    logic           full;
    logic           empty;
    stack_op_t      op;
    cause_t         fail_det;
    cause_t         fail_next;
    cause_t         cause;
    logic           parity_next;
    logic           res_valid;
    out_item_t      res;

    cause_t         fail_reg;
    logic           parity_reg;
    logic           m_valid_reg;
    out_item_t      m_data_reg;
    logic           skid_valid_reg;
    out_item_t      skid_data_reg;

    bbc_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .count    (count),
        .top_kind (top_kind)
    );

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign full    = (count == CW'(STACK_DEPTH));
    assign empty   = (count == '0);

    always_comb begin
        is_open = s_data.char_byte inside {CHAR_OPEN_PAREN, CHAR_OPEN_SQUARE,
                                           CHAR_OPEN_CURLY};
        case (s_data.char_byte)
            CHAR_OPEN_PAREN:  open_kind = KIND_PAREN;
            CHAR_OPEN_SQUARE: open_kind = KIND_SQUARE;
            CHAR_OPEN_CURLY:  open_kind = KIND_CURLY;
            default:          open_kind = KIND_NONE;
        endcase
        case (s_data.char_byte)
            CHAR_CLOSE_PAREN:  close_kind = KIND_PAREN;
            CHAR_CLOSE_SQUARE: close_kind = KIND_SQUARE;
            CHAR_CLOSE_CURLY:  close_kind = KIND_CURLY;
            default:           close_kind = KIND_NONE;
        endcase
        is_close = (close_kind != KIND_NONE);
    end

    always_comb begin
        op.push      = accept && is_open && !full;
        op.pop       = accept && !is_open && !empty;
        op.clear     = accept && s_data.last;
        op.push_kind = open_kind;
    end

    always_comb begin
        if (is_open && full) begin
            fail_det = CAUSE_OVERFLOW;
        end else if (!is_open && empty) begin
            fail_det = CAUSE_EMPTY;
        end else if (is_close && (top_kind != close_kind)) begin
            fail_det = CAUSE_MISMATCH;
        end else begin
            fail_det = CAUSE_OK;
        end
        fail_next   = (fail_reg == CAUSE_OK) ? fail_det : fail_reg;
        parity_next = !parity_reg;

        count_after = count;
        if (op.push) begin
            count_after = count + CW'(1);
        end else if (op.pop) begin
            count_after = count - CW'(1);
        end

        if (parity_next) begin
            cause = CAUSE_ODD;
        end else if (fail_next != CAUSE_OK) begin
            cause = fail_next;
        end else if (count_after != '0) begin
            cause = CAUSE_OPEN;
        end else begin
            cause = CAUSE_OK;
        end
        res.balanced = (cause == CAUSE_OK);
        res.cause    = cause;
        res_valid    = accept && s_data.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_reg   <= CAUSE_OK;
            parity_reg <= 1'b0;
        end else if (accept) begin
            if (s_data.last) begin
                fail_reg   <= CAUSE_OK;
                parity_reg <= 1'b0;
            end else begin
                fail_reg   <= fail_next;
                parity_reg <= parity_next;
            end
        end
    end

    // two-entry output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end
        if (res_valid && m_valid_reg && !m_ready) begin
            skid_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BBC_ASSERT(a_count_bound, aclk, aresetn, count <= CW'(STACK_DEPTH))
    `BBC_ASSERT(a_skid_behind_out, aclk, aresetn, !skid_valid_reg || m_valid_reg)
    `BBC_ASSERT(a_fail_code, aclk, aresetn,
        fail_reg == CAUSE_OK || fail_reg == CAUSE_MISMATCH ||
        fail_reg == CAUSE_EMPTY || fail_reg == CAUSE_OVERFLOW)
    `BBC_ASSERT_NEXT(a_last_clears, aclk, aresetn, res_valid,
        count == '0 && fail_reg == CAUSE_OK && !parity_reg && m_valid_reg)

endmodule

`default_nettype wire

// ===== tb/bracket_balance_checker_top_test.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// bracket_balance_checker_top_test
// drives byte strings into the bracket checker and compares every verdict
// with a cycle-free model of the stack, the latched failure and the length
// parity; directed corner strings first, then full and overflowing stacks,
// then random nested strings with corruption and noise, gaps on both
// sides, and a final stretch at full rate
module bracket_balance_checker_top_test;
    import bbc_pkg::*;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    kind_t     kind_stack[STACK_DEPTH];
    int        depth_cnt = 0;
    cause_t    first_fail = CAUSE_OK;
    bit        odd_len = 1'b0;
    out_item_t verdict_q[$];

    logic [7:0] text_q[$];
    int        errors = 0;
    int        item_cnt = 0;
    bit        gaps_on = 1'b1;
    int        stall_left = 0;
    int        idle_cycles = 0;

    bracket_balance_checker_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic kind_t opener_kind(input logic [7:0] ch);
        case (ch)
            CHAR_OPEN_PAREN:  return KIND_PAREN;
            CHAR_OPEN_SQUARE: return KIND_SQUARE;
            CHAR_OPEN_CURLY:  return KIND_CURLY;
            default:          return KIND_NONE;
        endcase
    endfunction

    function automatic kind_t closer_kind(input logic [7:0] ch);
        case (ch)
            CHAR_CLOSE_PAREN:  return KIND_PAREN;
            CHAR_CLOSE_SQUARE: return KIND_SQUARE;
            CHAR_CLOSE_CURLY:  return KIND_CURLY;
            default:           return KIND_NONE;
        endcase
    endfunction

    function automatic logic [7:0] opener_char(input kind_t k);
        case (k)
            KIND_PAREN:  return CHAR_OPEN_PAREN;
            KIND_SQUARE: return CHAR_OPEN_SQUARE;
            default:     return CHAR_OPEN_CURLY;
        endcase
    endfunction

    function automatic logic [7:0] closer_char(input kind_t k);
        case (k)
            KIND_PAREN:  return CHAR_CLOSE_PAREN;
            KIND_SQUARE: return CHAR_CLOSE_SQUARE;
            default:     return CHAR_CLOSE_CURLY;
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (opener_kind(b) != KIND_NONE || closer_kind(b) != KIND_NONE);
        return b;
    endfunction

    function automatic void note_failure(input cause_t c);
        if (first_fail == CAUSE_OK) first_fail = c;
    endfunction

    // advances the model by one character, queues a verdict on the last one
    function automatic void bracket_verdict_step(input in_item_t it);
        kind_t     k;
        kind_t     need;
        cause_t    verdict;
        out_item_t res;
        k = opener_kind(it.char_byte);
        if (k != KIND_NONE) begin
            if (depth_cnt >= STACK_DEPTH) begin
                note_failure(CAUSE_OVERFLOW);
            end else begin
                kind_stack[depth_cnt] = k;
                depth_cnt++;
            end
        end else if (depth_cnt == 0) begin
            note_failure(CAUSE_EMPTY);
        end else begin
            need = closer_kind(it.char_byte);
            if (need != KIND_NONE && kind_stack[depth_cnt - 1] != need)
                note_failure(CAUSE_MISMATCH);
            depth_cnt--;
        end
        odd_len = ~odd_len;
        if (it.last) begin
            if (odd_len)
                verdict = CAUSE_ODD;
            else if (first_fail != CAUSE_OK)
                verdict = first_fail;
            else if (depth_cnt != 0)
                verdict = CAUSE_OPEN;
            else
                verdict = CAUSE_OK;
            res.balanced = (verdict == CAUSE_OK);
            res.cause = verdict;
            verdict_q.insert(verdict_q.size(), res);
            depth_cnt = 0;
            first_fail = CAUSE_OK;
            odd_len = 1'b0;
        end
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic lst);
        in_item_t it;
        it.char_byte = ch;
        it.last = lst;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do
            @(posedge aclk);
        while (!s_ready);
        bracket_verdict_step(it);
        item_cnt++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic send_str(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.insert(text_q.size(), s[i]);
        send_text();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
    endtask

    // nested string; closers are sometimes replaced by plain bytes
    task automatic build_balanced(input int pairs, input int max_depth, input int push_pct);
        kind_t open_k[$];
        int    opened;
        kind_t k;
        text_q.delete();
        opened = 0;
        while (opened < pairs || open_k.size() != 0) begin
            if (opened < pairs && open_k.size() < max_depth &&
                (open_k.size() == 0 || $urandom_range(0, 99) < push_pct)) begin
                k = kind_t'($urandom_range(0, 2));
                open_k.insert(open_k.size(), k);
                text_q.insert(text_q.size(), opener_char(k));
                opened++;
            end else begin
                k = open_k.pop_back();
                text_q.insert(text_q.size(),
                              ($urandom_range(0, 4) == 0) ? plain_byte() : closer_char(k));
            end
        end
    endtask

    task automatic corrupt_text();
        int idx;
        idx = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 3))
            0: text_q[idx] = 8'($urandom_range(0, 255));
            1: if (text_q.size() > 1) text_q.delete(idx);
            2: text_q.insert(idx, ($urandom_range(0, 1) != 0) ?
                             opener_char(kind_t'($urandom_range(0, 2))) :
                             closer_char(kind_t'($urandom_range(0, 2))));
            default: while (text_q.size() > idx + 1) void'(text_q.pop_back());
        endcase
    endtask

    task automatic build_noise();
        int len;
        text_q.delete();
        len = $urandom_range(1, 12);
        repeat (len) begin
            if ($urandom_range(0, 1) != 0)
                text_q.insert(text_q.size(), ($urandom_range(0, 1) != 0) ?
                              opener_char(kind_t'($urandom_range(0, 2))) :
                              closer_char(kind_t'($urandom_range(0, 2))));
            else
                text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_directed_cases();
        send_str("()");
        send_str("[]");
        send_str("{}");
        send_str("(]");
        send_str(")(");
        send_str("((");
        send_str("(");
        send_str("([)]");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(CHAR_OPEN_CURLY, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_stack_limit();
        wait_drained();
        build_balanced(STACK_DEPTH, STACK_DEPTH, 100);
        send_text();
        build_balanced(STACK_DEPTH + 1, STACK_DEPTH + 1, 100);
        send_text();
    endtask

    task automatic test_random_strings(input int n_items, input bit pause_mid);
        int target;
        int pick;
        bit paused;
        target = item_cnt + n_items;
        paused = 1'b0;
        while (item_cnt < target) begin
            if (pause_mid && !paused && item_cnt > target - n_items / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                build_balanced(STACK_DEPTH + $urandom_range(0, 4),
                               STACK_DEPTH - 3 + $urandom_range(0, 5), 95);
            end else if (pick < 14) begin
                build_noise();
            end else begin
                build_balanced($urandom_range(1, 12), $urandom_range(1, 16), 50);
                if ($urandom_range(0, 9) < 3) corrupt_text();
            end
            send_text();
        end
    endtask

    task automatic test_back_to_back();
        wait_drained();
        gaps_on = 1'b0;
        test_random_strings(250, 1'b0);
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (aresetn && gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end

    always @(posedge aclk) begin
        out_item_t exp_v;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("verdict with none expected: balanced %0d cause %0d",
                       m_data.balanced, m_data.cause);
                errors++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (m_data.balanced !== exp_v.balanced) begin
                    $error("balanced: expected %0d actual %0d", exp_v.balanced, m_data.balanced);
                    errors++;
                end
                if (m_data.cause !== exp_v.cause) begin
                    $error("cause: expected %0d actual %0d", exp_v.cause, m_data.cause);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int wait_cnt;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_stack_limit();
        test_random_strings(1430, 1'b1);
        test_back_to_back();
        s_valid <= 1'b0;
        wait_cnt = 0;
        while (verdict_q.size() != 0 && wait_cnt < 1000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (20) @(posedge aclk);
        if (verdict_q.size() != 0) begin
            $error("%0d expected verdicts never arrived", verdict_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
